// ===== rtl/sacl_pkg.sv =====
// Shared types, constants and helper functions of the 8-way LRU tag directory.
// No dependencies; every other file but sacl_ram refers to it by scoped names.
`timescale 1ns / 1ps

package sacl_pkg;

  localparam int WAYS        = 8;
  localparam int WAY_W       = 3;
  localparam int RANK_W      = 3;
  localparam int SET_FIELD_W = 1;
  localparam int TAG_FIELD_W = 26;
  localparam int PEN_W       = 16;
  localparam int TOTAL_W     = 32;
  localparam int META_W      = WAYS * (1 + RANK_W);
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_IDX_W   = 2;

  localparam int DEF_SETS     = 2;
  localparam int DEF_TAG_BITS = 26;

  localparam logic [RANK_W-1:0] TOP_RANK = 3'd7;

  localparam logic [PEN_W-1:0] HIT_PEN_RST    = 16'd4;
  localparam logic [PEN_W-1:0] MISS_PEN_A_RST = 16'd836;
  localparam logic [PEN_W-1:0] MISS_PEN_B_RST = 16'd108;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIT_PEN    = 2'd0,
    CFG_MISS_PEN_A = 2'd1,
    CFG_MISS_PEN_B = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } back_state_t;

  typedef struct packed {
    logic [PEN_W-1:0] hit_pen;
    logic [PEN_W-1:0] miss_pen_a;
    logic [PEN_W-1:0] miss_pen_b;
  } penalties_t;

  // Row of a set's metadata after reset: low WAYS bits valid (all clear),
  // then one rank field per way equal to its way number.
  function automatic logic [META_W-1:0] meta_reset();
    logic [META_W-1:0] row;
    row = '0;
    for (int w = 0; w < WAYS; w++) begin
      row[WAYS + w*RANK_W +: RANK_W] = RANK_W'(w);
    end
    return row;
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] acc,
                                                 input logic [PEN_W-1:0]   inc);
    logic [TOTAL_W:0] sum;
    sum = {1'b0, acc} + {{(TOTAL_W + 1 - PEN_W){1'b0}}, inc};
    return sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
  endfunction

endpackage

// ===== rtl/sacl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sacl_front.sv =====
// Front end: accept accesses, fold the set index into range, trim the tag,
// and hold them in a two-entry queue for the back end. Uses sacl_pkg.
`timescale 1ns / 1ps

module sacl_front #(
  parameter int SETS     = sacl_pkg::DEF_SETS,
  parameter int TAG_BITS = sacl_pkg::DEF_TAG_BITS,
  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1,
  localparam int TW    = (TAG_BITS < sacl_pkg::TAG_FIELD_W) ? TAG_BITS
                                                            : sacl_pkg::TAG_FIELD_W
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sacl_pkg::SET_FIELD_W-1:0]    in_set,
  input  logic [sacl_pkg::TAG_FIELD_W-1:0]    in_tag,
  output logic                                q_valid,
  input  logic                                q_pop,
  output logic [SET_W-1:0]                    q_set,
  output logic [TW-1:0]                       q_tag
);

  logic [SET_W-1:0] set_cls;
  logic [TW-1:0]    tag_cls;
  logic [SET_W-1:0] q_set_r [2];
  logic [TW-1:0]    q_tag_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push;

  // Wrap the set into range; only the low tag bits take part in compares.
  assign set_cls = (SETS > 1) ? SET_W'(in_set) : '0;
  assign tag_cls = in_tag[TW-1:0];

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_set    = q_set_r[rd_ptr_r];
  assign q_tag    = q_tag_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    unique case ({push, q_pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_set_r[wr_ptr_r] <= set_cls;
      q_tag_r[wr_ptr_r] <= tag_cls;
    end
  end

endmodule

// ===== rtl/sacl_back.sv =====
// Back end: clear the metadata after reset, then read a set's row, compare
// all ways, update LRU ranks, tags and stall totals. Uses sacl_pkg, sacl_ram.
`timescale 1ns / 1ps

module sacl_back #(
  parameter int SETS     = sacl_pkg::DEF_SETS,
  parameter int TAG_BITS = sacl_pkg::DEF_TAG_BITS,
  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1,
  localparam int TW    = (TAG_BITS < sacl_pkg::TAG_FIELD_W) ? TAG_BITS
                                                            : sacl_pkg::TAG_FIELD_W
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sacl_pkg::penalties_t              pen,
  input  logic                              q_valid,
  output logic                              q_pop,
  input  logic [SET_W-1:0]                  q_set,
  input  logic [TW-1:0]                     q_tag,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hit,
  output logic [sacl_pkg::WAY_W-1:0]        out_way,
  output logic [sacl_pkg::TOTAL_W-1:0]      out_total_a,
  output logic [sacl_pkg::TOTAL_W-1:0]      out_total_b
);

  localparam int WAYS   = sacl_pkg::WAYS;
  localparam int RANK_W = sacl_pkg::RANK_W;
  localparam int META_W = sacl_pkg::META_W;
  localparam int ROW_W  = WAYS * TW;

  sacl_pkg::back_state_t state_r, state_nxt;

  logic [SET_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [SET_W-1:0] cur_set_r;
  logic [TW-1:0]    cur_tag_r;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_hit_r;
  logic [sacl_pkg::WAY_W-1:0]    out_way_r;
  logic [sacl_pkg::TOTAL_W-1:0]  total_a_r, total_a_nxt;
  logic [sacl_pkg::TOTAL_W-1:0]  total_b_r, total_b_nxt;
  logic                          load;

  logic              meta_we;
  logic [SET_W-1:0]  meta_waddr;
  logic [META_W-1:0] meta_wdata, meta_rd;
  logic              tag_we;
  logic [ROW_W-1:0]  tag_wdata, tag_rd;

  logic [WAYS-1:0]             valid;
  logic [RANK_W-1:0]           rank [WAYS];
  logic [RANK_W-1:0]           rank_new [WAYS];
  logic [WAYS-1:0]             valid_new;
  logic                        hit;
  logic [sacl_pkg::WAY_W-1:0]  hit_way, vic_way, used_way;
  logic [RANK_W-1:0]           old_rank;

  sacl_ram #(.WIDTH(META_W), .DEPTH(SETS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (q_set),
    .rdata (meta_rd)
  );

  sacl_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (cur_set_r),
    .wdata (tag_wdata),
    .raddr (q_set),
    .rdata (tag_rd)
  );

  // Compare and rank update on the row read for the current access.
  always_comb begin
    valid   = meta_rd[WAYS-1:0];
    hit     = 1'b0;
    hit_way = '0;
    vic_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      rank[w] = meta_rd[WAYS + w*RANK_W +: RANK_W];
    end
    // Scan downward so the lowest matching way wins.
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (valid[w] && tag_rd[w*TW +: TW] == cur_tag_r) begin
        hit     = 1'b1;
        hit_way = sacl_pkg::WAY_W'(w);
      end
      if (rank[w] == '0) begin
        vic_way = sacl_pkg::WAY_W'(w);
      end
    end
    used_way = hit ? hit_way : vic_way;
    old_rank = hit ? rank[hit_way] : '0;
    valid_new = valid;
    tag_wdata = tag_rd;
    for (int w = 0; w < WAYS; w++) begin
      if (sacl_pkg::WAY_W'(w) == used_way) begin
        rank_new[w]          = sacl_pkg::TOP_RANK;
        valid_new[w]         = 1'b1;
        tag_wdata[w*TW +: TW] = cur_tag_r;
      end else if (rank[w] > old_rank) begin
        rank_new[w] = rank[w] - RANK_W'(1);
      end else begin
        rank_new[w] = rank[w];
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    q_pop       = 1'b0;
    load        = 1'b0;
    meta_we     = 1'b0;
    tag_we      = 1'b0;
    meta_waddr  = cur_set_r;
    meta_wdata  = '0;
    meta_wdata[WAYS-1:0] = valid_new;
    for (int w = 0; w < WAYS; w++) begin
      meta_wdata[WAYS + w*RANK_W +: RANK_W] = rank_new[w];
    end
    unique case (state_r)
      sacl_pkg::ST_CLEAR: begin
        meta_we     = 1'b1;
        meta_waddr  = clr_cnt_r;
        meta_wdata  = sacl_pkg::meta_reset();
        clr_cnt_nxt = clr_cnt_r + SET_W'(1);
        if (clr_cnt_r == SET_W'(SETS - 1)) begin
          state_nxt = sacl_pkg::ST_IDLE;
        end
      end
      sacl_pkg::ST_IDLE: begin
        // Start a lookup only when the result slot is free by next cycle.
        if (q_valid && (!out_valid_r || out_ready)) begin
          q_pop     = 1'b1;
          state_nxt = sacl_pkg::ST_LOOK;
        end
      end
      sacl_pkg::ST_LOOK: begin
        meta_we   = 1'b1;
        tag_we    = !hit;
        load      = 1'b1;
        state_nxt = sacl_pkg::ST_IDLE;
      end
      default: state_nxt = sacl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
    total_a_nxt = total_a_r;
    total_b_nxt = total_b_r;
    if (load) begin
      total_a_nxt = sacl_pkg::sat_add(total_a_r, hit ? pen.hit_pen : pen.miss_pen_a);
      total_b_nxt = sacl_pkg::sat_add(total_b_r, hit ? pen.hit_pen : pen.miss_pen_b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sacl_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      total_a_r   <= '0;
      total_b_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      total_a_r   <= total_a_nxt;
      total_b_r   <= total_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_set_r <= q_set;
      cur_tag_r <= q_tag;
    end
    if (load) begin
      out_hit_r <= hit;
      out_way_r <= used_way;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_way     = out_way_r;
  assign out_total_a = total_a_r;
  assign out_total_b = total_b_r;

endmodule

// ===== rtl/set_assoc_lru_cache_tags.sv =====
// Top level of the 8-way set-associative tag directory with true LRU ranks.
// Uses sacl_pkg, sacl_front, sacl_back (which holds the sacl_ram instances).
//
// Usage:
//   in_*  : one access per item; tdata carries set_index and tag_value.
//   out_* : one result per access, in order: hit, way used, stall totals.
//   cfg_* : register writes (hit penalty, miss penalty A, miss penalty B);
//           always ready, write only while no access is in flight.
// Path: an accepted item passes through the two-entry queue, the RAM read, the
//   compare and write-back, and the output register before out_tvalid shows it.
// Ordering: each access reads its set's row from the metadata and tag RAMs
//   (registered read) and writes it back the next cycle before the following
//   access may read, so the back end takes no new item until the last is done.
// Reset: synchronous, active low. Penalties return to 4/836/108, totals to
//   zero; then a clearing pass rewrites every set's metadata
//   row (all ways invalid, rank equal to way number). Items queue up during
//   the pass (two at most) and are processed after it.
// Stall: a result waits in the output register while out_tready is low; the
//   two-entry queue keeps taking items until full, then in_tready drops.
`timescale 1ns / 1ps

module set_assoc_lru_cache_tags #(
  parameter int SETS     = sacl_pkg::DEF_SETS,
  parameter int TAG_BITS = sacl_pkg::DEF_TAG_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [0] set_index, [26:1] tag_value, [31:27] zero
  input  logic [sacl_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] hit, [3:1] way_used, [35:4] stall_total_a, [67:36] stall_total_b,
  // [71:68] zero
  output logic [sacl_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sacl_pkg::PEN_W-1:0]          cfg_data
);

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int TW    = (TAG_BITS < sacl_pkg::TAG_FIELD_W) ? TAG_BITS
                                                            : sacl_pkg::TAG_FIELD_W;

  sacl_pkg::penalties_t pen_r, pen_nxt;

  logic                              q_valid, q_pop;
  logic [SET_W-1:0]                  q_set;
  logic [TW-1:0]                     q_tag;
  logic                              res_hit;
  logic [sacl_pkg::WAY_W-1:0]        res_way;
  logic [sacl_pkg::TOTAL_W-1:0]      res_total_a, res_total_b;

  // Configuration: always ready; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_comb begin
    pen_nxt = pen_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        sacl_pkg::CFG_HIT_PEN:    pen_nxt.hit_pen    = cfg_data;
        sacl_pkg::CFG_MISS_PEN_A: pen_nxt.miss_pen_a = cfg_data;
        sacl_pkg::CFG_MISS_PEN_B: pen_nxt.miss_pen_b = cfg_data;
        default:                  pen_nxt = pen_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_r.hit_pen    <= sacl_pkg::HIT_PEN_RST;
      pen_r.miss_pen_a <= sacl_pkg::MISS_PEN_A_RST;
      pen_r.miss_pen_b <= sacl_pkg::MISS_PEN_B_RST;
    end else begin
      pen_r <= pen_nxt;
    end
  end

  // Front: classify and queue accesses.
  sacl_front #(.SETS(SETS), .TAG_BITS(TAG_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_set   (in_tdata[0]),
    .in_tag   (in_tdata[sacl_pkg::TAG_FIELD_W:1]),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_set    (q_set),
    .q_tag    (q_tag)
  );

  // Back: lookup, LRU update, totals, result register.
  sacl_back #(.SETS(SETS), .TAG_BITS(TAG_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pen         (pen_r),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_set       (q_set),
    .q_tag       (q_tag),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_hit     (res_hit),
    .out_way     (res_way),
    .out_total_a (res_total_a),
    .out_total_b (res_total_b)
  );

  assign out_tdata = {4'b0000, res_total_b, res_total_a, res_way, res_hit};

endmodule

// ===== rtl/sacl_checker.sv =====
// Port-level checks of set_assoc_lru_cache_tags, bound to the top level.
// Uses sacl_pkg.
`timescale 1ns / 1ps

module sacl_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [sacl_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // Reset empties the result register.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A stalled result holds.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Each access needs a read then a write-back, so results never come back to back.
  a_no_b2b: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && out_tready |=> !out_tvalid)
    else $error("results on consecutive cycles");

  // Pad bits above the last field stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid |-> out_tdata[71:68] == 4'b0000)
    else $error("nonzero pad bits in result");

endmodule

bind set_assoc_lru_cache_tags sacl_checker u_checker (.*);
